[hw/rtl/rca_pkg.sv]
package rca_pkg;

  localparam int MAX_VARS_DEF = 16;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 4;
  localparam int TOT_W        = 6;

  localparam logic [CFG_IDX_W-1:0] REG_INDEP = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEP   = 4'd1;

  localparam logic [2:0] OP_ACC   = 3'd0;
  localparam logic [2:0] OP_MEAN  = 3'd1;
  localparam logic [2:0] OP_COV   = 3'd2;
  localparam logic [2:0] OP_SIGMA = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_IDX = 2'd1;
  localparam logic [1:0] ST_FEW = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] sample_value;
    logic [4:0]         row_index;
    logic [4:0]         col_index;
    logic               last_of_event;
  } in_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [1:0]         status;
    logic [31:0]        events_seen;
  } out_t;

endpackage

[hw/rtl/running_covariance_accumulator_unit.sv]
// One-pass (Welford) mean and covariance accumulator. Each accumulate item
// carries one element of an event vector of min(independent_count +
// dependent_count, MAX_VARS) values; read items return a mean, a covariance
// or a sigma, and every item gives exactly one result item. All arithmetic
// runs on a single 32x32 multiplier (four partial products per 64x64
// multiply), a one-bit-per-cycle restoring divider and a two-bits-per-cycle
// square root, under one sequencer, so the block takes one item at a time.
// An accumulate item at position p of a later event runs the multiplier
// loop over the covariance row up to p, and the first element of such an
// event first computes the count reciprocal on the divider. An element of
// the first event only stores its sample as the mean. A mean read only
// reads the mean memory; a covariance read also runs the divider, and a
// sigma read runs the divider and then the root unit. A read with a bad
// index or too few events and an unused operation go straight to the
// result. After reset, after a clear item and at the start of the first
// event, a clearing pass walks the covariance memory; configuration writes
// are still taken during it. A finished result waits in an output register,
// and the next item can be accepted while it waits.
module running_covariance_accumulator_unit #(
  parameter int MAX_VARS = rca_pkg::MAX_VARS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rca_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rca_pkg::out_t                       out_data,
  input  logic                                cfg_we,
  input  logic [rca_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rca_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import rca_pkg::*;

  localparam int VW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int AW = $clog2(MAX_VARS * MAX_VARS);
  localparam logic [47:0] S48_MAX = {1'b0, {47{1'b1}}};
  localparam logic [47:0] S48_MIN = {1'b1, {47{1'b0}}};
  localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_WDIV, S_ELEM, S_MRD, S_MWAIT, S_DELTA, S_KRD, S_KWAIT,
    S_KLOAD, S_MUL1, S_MUL2, S_WR1, S_WR2, S_MUL3, S_POS, S_RRD, S_RWAIT,
    S_RDIV, S_RSQ, S_FIN
  } state_t;

  function automatic logic [47:0] mag48(input logic [47:0] v);
    mag48 = v[47] ? (48'd0 - v) : v;
  endfunction

  function automatic logic [47:0] clamp49(input logic [48:0] v);
    if (v[48] != v[47]) clamp49 = v[48] ? S48_MIN : S48_MAX;
    else clamp49 = v[47:0];
  endfunction

  function automatic logic [AW-1:0] pair_addr(input logic [4:0] a, input logic [4:0] b);
    pair_addr = AW'(int'(a) * MAX_VARS + int'(b));
  endfunction

  // Configuration and architectural state.
  logic [3:0]  indep_r, dep_r;
  logic [31:0] cnt_r;
  logic [4:0]  pos_r;
  logic [31:0] alpha_r, beta_r;

  // Sequencer and latched item.
  state_t       state_r;
  logic [2:0]   op_r;
  logic [47:0]  x_r;
  logic         last_r;
  logic [4:0]   k_r;
  logic [AW-1:0] clr_idx_r;
  logic         clr_means_r, clr_to_elem_r;
  logic [63:0]  res_val_r;
  logic [1:0]   res_st_r;
  logic         out_valid_r;
  out_t         out_r;

  // Datapath registers.
  logic [47:0]  dp_r, mean_hold_r;
  logic         dk_neg_r, s_neg_r;
  logic [63:0]  sum_hold_r, sum_new_r;
  logic [63:0]  mul_a_r, mul_b_r;
  logic [63:0]  pp_r;
  logic [1:0]   psh_r;
  logic [127:0] acc_r;
  logic [2:0]   mcnt_r;
  logic [63:0]  dv_q_r;
  logic [31:0]  dv_rem_r, dv_dsr_r;
  logic [6:0]   icnt_r;
  logic [95:0]  sq_src_r;
  logic [51:0]  sq_rem_r;
  logic [47:0]  sq_root_r;

  // Memories.
  logic [47:0] mean_mem [MAX_VARS];
  logic [47:0] delta_mem [MAX_VARS];
  logic [63:0] cov_mem [MAX_VARS*MAX_VARS];
  logic [VW-1:0] mean_addr_r, dl_addr_r;
  logic [AW-1:0] cov_addr_r;
  logic [47:0] mean_q_r, delta_q_r;
  logic [63:0] cov_q_r;

  logic          mean_we, delta_we, cov_we;
  logic [VW-1:0] mean_wa, delta_wa;
  logic [AW-1:0] cov_wa;
  logic [47:0]   mean_wd, delta_wd;
  logic [63:0]   cov_wd;

  // Combinational helpers.
  logic [4:0]        sum5;
  logic [TOT_W-1:0]  total;
  logic              accept;
  logic [31:0]       cnt_inc;
  logic [63:0]       pp;
  logic [63:0]       mul_res;
  logic [32:0]       dv_sh;
  logic              dv_ge;
  logic [31:0]       dv_rem_nxt;
  logic [63:0]       dv_q_nxt;
  logic [51:0]       sq_sh, sq_trial;
  logic              sq_ge;
  logic [51:0]       sq_rem_nxt;
  logic [47:0]       sq_root_nxt;
  logic [48:0]       dp_wide;
  logic [64:0]       sum_wide;
  logic [64:0]       term;
  logic [63:0]       sum_sat;
  logic [48:0]       mean_wide;
  logic [4:0]        rd_col;

  assign sum5     = 5'(indep_r) + 5'(dep_r);
  assign total    = (6'(sum5) > 6'(MAX_VARS)) ? 6'(MAX_VARS) : 6'(sum5);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign cnt_inc  = (cnt_r == 32'hFFFF_FFFF) ? cnt_r : cnt_r + 32'd1;
  assign rd_col   = (in_data.operation == OP_COV) ? in_data.col_index : in_data.row_index;

  // The multiplier works on one 32-bit half of each operand per cycle.
  assign pp = (mcnt_r[1] ? mul_a_r[63:32] : mul_a_r[31:0]) *
              (mcnt_r[0] ? mul_b_r[63:32] : mul_b_r[31:0]);
  assign mul_res = (acc_r[127:96] != 32'd0) ? {64{1'b1}} : acc_r[95:32];

  assign dv_sh      = {dv_rem_r, dv_q_r[63]};
  assign dv_ge      = dv_sh >= {1'b0, dv_dsr_r};
  assign dv_rem_nxt = dv_ge ? 32'(dv_sh - {1'b0, dv_dsr_r}) : dv_sh[31:0];
  assign dv_q_nxt   = {dv_q_r[62:0], dv_ge};

  assign sq_sh       = {sq_rem_r[49:0], sq_src_r[95:94]};
  assign sq_trial    = {2'b00, sq_root_r, 2'b01};
  assign sq_ge       = sq_sh >= sq_trial;
  assign sq_rem_nxt  = sq_ge ? (sq_sh - sq_trial) : sq_sh;
  assign sq_root_nxt = {sq_root_r[46:0], sq_ge};

  assign dp_wide   = {x_r[47], x_r} - {mean_q_r[47], mean_q_r};
  assign term      = (dp_r[47] ^ dk_neg_r) ? (65'd0 - {1'b0, mul_res}) : {1'b0, mul_res};
  assign sum_wide  = {sum_hold_r[63], sum_hold_r} + term;
  assign sum_sat   = (sum_wide[64] != sum_wide[63]) ? (sum_wide[64] ? S64_MIN : S64_MAX)
                                                    : sum_wide[63:0];
  assign mean_wide = dp_r[47] ? ({mean_hold_r[47], mean_hold_r} - mul_res[48:0])
                              : ({mean_hold_r[47], mean_hold_r} + mul_res[48:0]);

  // Memory write selection per sequencer state.
  always_comb begin
    mean_we  = 1'b0;
    mean_wa  = pos_r[VW-1:0];
    mean_wd  = x_r;
    delta_we = 1'b0;
    delta_wa = pos_r[VW-1:0];
    delta_wd = dp_r;
    cov_we   = 1'b0;
    cov_wa   = pair_addr(pos_r, k_r);
    cov_wd   = sum_new_r;
    case (state_r)
      S_CLR: begin
        cov_we  = 1'b1;
        cov_wa  = clr_idx_r;
        cov_wd  = 64'd0;
        mean_we = clr_means_r && (int'(clr_idx_r) < MAX_VARS);
        mean_wa = clr_idx_r[VW-1:0];
        mean_wd = 48'd0;
      end
      S_ELEM: begin
        mean_we = ({1'b0, pos_r} < total) && (cnt_r == 32'd1);
      end
      S_DELTA: begin
        delta_we = 1'b1;
      end
      S_WR1: begin
        cov_we = 1'b1;
      end
      S_WR2: begin
        cov_we = 1'b1;
        cov_wa = pair_addr(k_r, pos_r);
      end
      S_MUL3: begin
        mean_we = (mcnt_r == 3'd5);
        mean_wd = clamp49(mean_wide);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mean_we) mean_mem[mean_wa] <= mean_wd;
    mean_q_r <= mean_mem[mean_addr_r];
  end

  always_ff @(posedge clk) begin
    if (delta_we) delta_mem[delta_wa] <= delta_wd;
    delta_q_r <= delta_mem[dl_addr_r];
  end

  always_ff @(posedge clk) begin
    if (cov_we) cov_mem[cov_wa] <= cov_wd;
    cov_q_r <= cov_mem[cov_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      op_r          <= OP_ACC;
      clr_idx_r     <= '0;
      clr_means_r   <= 1'b1;
      clr_to_elem_r <= 1'b0;
      indep_r       <= 4'd1;
      dep_r         <= 4'd1;
      cnt_r         <= 32'd0;
      pos_r         <= 5'd0;
      alpha_r       <= 32'd0;
      beta_r        <= 32'd0;
      out_valid_r   <= 1'b0;
      mcnt_r        <= 3'd0;
      icnt_r        <= 7'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_INDEP) indep_r <= cfg_wdata;
        else if (cfg_index == REG_DEP) dep_r <= cfg_wdata;
      end
      // The result stage handles its own handshake while a result is loaded.
      if (out_valid_r && out_ready && (state_r != S_FIN)) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r      <= in_data.operation;
            x_r       <= {in_data.sample_value, 16'd0};
            last_r    <= in_data.last_of_event;
            res_val_r <= 64'd0;
            res_st_r  <= ST_OK;
            case (in_data.operation)
              OP_ACC: begin
                if (pos_r == 5'd0) begin
                  cnt_r <= cnt_inc;
                  if (cnt_inc == 32'd1) begin
                    // The first event starts from empty sums.
                    clr_idx_r     <= '0;
                    clr_means_r   <= 1'b0;
                    clr_to_elem_r <= 1'b1;
                    state_r       <= S_CLR;
                  end else begin
                    dv_q_r   <= 64'h1_0000_0000 + 64'(cnt_inc >> 1);
                    dv_rem_r <= 32'd0;
                    dv_dsr_r <= cnt_inc;
                    icnt_r   <= 7'd0;
                    state_r  <= S_WDIV;
                  end
                end else begin
                  state_r <= S_ELEM;
                end
              end
              OP_MEAN: begin
                if ({1'b0, in_data.row_index} >= total) begin
                  res_st_r <= ST_IDX;
                  state_r  <= S_FIN;
                end else if (cnt_r == 32'd0) begin
                  res_st_r <= ST_FEW;
                  state_r  <= S_FIN;
                end else begin
                  mean_addr_r <= in_data.row_index[VW-1:0];
                  state_r     <= S_RRD;
                end
              end
              OP_COV, OP_SIGMA: begin
                if (({1'b0, in_data.row_index} >= total) || ({1'b0, rd_col} >= total)) begin
                  res_st_r <= ST_IDX;
                  state_r  <= S_FIN;
                end else if (cnt_r < 32'd2) begin
                  res_st_r <= ST_FEW;
                  state_r  <= S_FIN;
                end else begin
                  cov_addr_r <= pair_addr(in_data.row_index, rd_col);
                  state_r    <= S_RRD;
                end
              end
              OP_CLEAR: begin
                cnt_r         <= 32'd0;
                pos_r         <= 5'd0;
                alpha_r       <= 32'd0;
                beta_r        <= 32'd0;
                clr_idx_r     <= '0;
                clr_means_r   <= 1'b1;
                clr_to_elem_r <= 1'b0;
                state_r       <= S_CLR;
              end
              default: begin
                state_r <= S_FIN;
              end
            endcase
          end
        end

        S_CLR: begin
          clr_idx_r <= clr_idx_r + AW'(1);
          if (int'(clr_idx_r) == MAX_VARS * MAX_VARS - 1) begin
            // A clear item owes a result once its pass is done; the pass
            // after reset does not.
            if (clr_to_elem_r) state_r <= S_ELEM;
            else if (op_r == OP_CLEAR) state_r <= S_FIN;
            else state_r <= S_IDLE;
          end
        end

        S_WDIV: begin
          dv_q_r   <= dv_q_nxt;
          dv_rem_r <= dv_rem_nxt;
          icnt_r   <= icnt_r + 7'd1;
          if (icnt_r == 7'd63) begin
            beta_r  <= dv_q_nxt[31:0];
            alpha_r <= 32'd0 - dv_q_nxt[31:0];
            state_r <= S_ELEM;
          end
        end

        S_ELEM: begin
          if (({1'b0, pos_r} < total) && (cnt_r != 32'd1)) begin
            mean_addr_r <= pos_r[VW-1:0];
            state_r     <= S_MRD;
          end else begin
            state_r <= S_POS;
          end
        end

        S_MRD: state_r <= S_MWAIT;

        S_MWAIT: begin
          dp_r        <= clamp49(dp_wide);
          mean_hold_r <= mean_q_r;
          k_r         <= 5'd0;
          state_r     <= S_DELTA;
        end

        S_DELTA: state_r <= S_KRD;

        S_KRD: begin
          cov_addr_r <= pair_addr(pos_r, k_r);
          dl_addr_r  <= k_r[VW-1:0];
          state_r    <= S_KWAIT;
        end

        S_KWAIT: state_r <= S_KLOAD;

        S_KLOAD: begin
          mul_a_r    <= 64'(mag48(dp_r));
          mul_b_r    <= 64'(mag48(delta_q_r));
          dk_neg_r   <= delta_q_r[47];
          sum_hold_r <= cov_q_r;
          acc_r      <= 128'd0;
          mcnt_r     <= 3'd0;
          state_r    <= S_MUL1;
        end

        S_MUL1, S_MUL2, S_MUL3: begin
          if (mcnt_r < 3'd4) begin
            pp_r  <= pp;
            psh_r <= 2'(mcnt_r[1]) + 2'(mcnt_r[0]);
          end
          if (mcnt_r != 3'd0 && mcnt_r != 3'd5)
            acc_r <= acc_r + (128'(pp_r) << {psh_r, 5'd0});
          if (mcnt_r != 3'd5) begin
            mcnt_r <= mcnt_r + 3'd1;
          end else begin
            mcnt_r <= 3'd0;
            acc_r  <= 128'd0;
            case (state_r)
              S_MUL1: begin
                // Scale the delta product by alpha.
                mul_a_r <= mul_res;
                mul_b_r <= 64'(alpha_r);
                state_r <= S_MUL2;
              end
              S_MUL2: begin
                sum_new_r <= sum_sat;
                state_r   <= S_WR1;
              end
              default: begin
                state_r <= S_POS;
              end
            endcase
          end
        end

        S_WR1: begin
          if (k_r == pos_r) begin
            mul_a_r <= 64'(mag48(dp_r));
            mul_b_r <= 64'(beta_r);
            acc_r   <= 128'd0;
            mcnt_r  <= 3'd0;
            state_r <= S_MUL3;
          end else begin
            state_r <= S_WR2;
          end
        end

        S_WR2: begin
          k_r     <= k_r + 5'd1;
          state_r <= S_KRD;
        end

        S_POS: begin
          if (last_r) pos_r <= 5'd0;
          else if (pos_r != 5'd31) pos_r <= pos_r + 5'd1;
          state_r <= S_FIN;
        end

        S_RRD: state_r <= S_RWAIT;

        S_RWAIT: begin
          if (op_r == OP_MEAN) begin
            res_val_r <= {{16{mean_q_r[47]}}, mean_q_r};
            state_r   <= S_FIN;
          end else if ((op_r == OP_SIGMA) && cov_q_r[63]) begin
            // A negative variance reads as zero sigma.
            state_r <= S_FIN;
          end else begin
            s_neg_r  <= cov_q_r[63];
            dv_q_r   <= cov_q_r[63] ? (64'd0 - cov_q_r) : cov_q_r;
            dv_rem_r <= 32'd0;
            dv_dsr_r <= cnt_r - 32'd1;
            icnt_r   <= 7'd0;
            state_r  <= S_RDIV;
          end
        end

        S_RDIV: begin
          dv_q_r   <= dv_q_nxt;
          dv_rem_r <= dv_rem_nxt;
          icnt_r   <= icnt_r + 7'd1;
          if (icnt_r == 7'd63) begin
            if (op_r == OP_COV) begin
              res_val_r <= s_neg_r ? (64'd0 - dv_q_nxt) : dv_q_nxt;
              state_r   <= S_FIN;
            end else begin
              sq_src_r  <= {dv_q_nxt, 32'd0};
              sq_rem_r  <= 52'd0;
              sq_root_r <= 48'd0;
              icnt_r    <= 7'd0;
              state_r   <= S_RSQ;
            end
          end
        end

        S_RSQ: begin
          sq_src_r  <= sq_src_r << 2;
          sq_rem_r  <= sq_rem_nxt;
          sq_root_r <= sq_root_nxt;
          icnt_r    <= icnt_r + 7'd1;
          if (icnt_r == 7'd47) begin
            res_val_r <= 64'(sq_root_nxt);
            state_r   <= S_FIN;
          end
        end

        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r         <= 1'b1;
            out_r.result_value  <= res_val_r;
            out_r.status        <= res_st_r;
            out_r.events_seen   <= cnt_r;
            state_r             <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
